// ===== rtl/buzzer_pulse_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the buzzer pulse controller.
// Define NO_ASSERTIONS to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef BUZZER_PULSE_CONTROLLER_UNIT_MACROS_SVH
`define BUZZER_PULSE_CONTROLLER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition in one cycle implies a condition in the same cycle.
`define BPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buzzer pulse controller: same-cycle check failed");
// Condition in one cycle implies a condition in the next cycle.
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buzzer pulse controller: next-cycle check failed");
`else
`define BPC_ASSERT_SAME(lbl, ante, cons)
`define BPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Buzzer pulse controller package
// Shared widths, codes and transaction types.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int FIELD_W        = 16;
  localparam int KIND_W         = 2;
  localparam int MODE_W         = 2;
  localparam int ERR_W          = 2;
  localparam int TIMER_W        = 32;
  localparam int TIME_WIDTH_DEF = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_ENABLE  = 2'd1,
    KIND_DISABLE = 2'd2,
    KIND_PULSE   = 2'd3
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_PULSE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ON    = 2'd1,
    EV_OFF   = 2'd2,
    EV_PULSE = 2'd3
  } event_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 2'd0,
    ERR_ZERO_ON    = 2'd1,
    ERR_ZERO_OFF   = 2'd2,
    ERR_ZERO_TOTAL = 2'd3
  } err_t;

  typedef enum logic [4:0] {
    ST_TO_ON    = 5'b00001,
    ST_WAIT_OFF = 5'b00010,
    ST_TO_OFF   = 5'b00100,
    ST_WAIT_ON  = 5'b01000,
    ST_FINAL    = 5'b10000
  } stage_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] on_time;
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] total_time;
  } item_t;

  typedef struct packed {
    logic  buzzer_level;
    mode_t mode;
    err_t  error;
  } result_t;

endpackage

// ===== rtl/bpc_if.sv =====
// ----------------------------------------------------------------------------
// Buzzer pulse controller channels
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface bpc_item_if;
  import bpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FIELD_W-1:0] on_time;
  logic [FIELD_W-1:0] period;
  logic [FIELD_W-1:0] total_time;

  modport source (output valid, kind, on_time, period, total_time, input ready);
  modport sink   (input valid, kind, on_time, period, total_time, output ready);
endinterface

interface bpc_result_if;
  import bpc_pkg::*;

  logic              valid;
  logic              ready;
  logic              buzzer_level;
  logic [MODE_W-1:0] mode;
  logic [ERR_W-1:0]  error;

  modport source (output valid, buzzer_level, mode, error, input ready);
  modport sink   (input valid, buzzer_level, mode, error, output ready);
endinterface

// ===== rtl/bpc_core.sv =====
// ----------------------------------------------------------------------------
// Buzzer pulse controller core
// Mode, pulse sequencer and timer state; applies one transaction per step.
// ----------------------------------------------------------------------------
`include "buzzer_pulse_controller_unit_macros.svh"

module bpc_core #(
  parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bpc_pkg::item_t    item,
  output bpc_pkg::result_t  result
);
  import bpc_pkg::*;

  localparam int IW = (TIME_WIDTH < FIELD_W) ? TIME_WIDTH : FIELD_W;

  mode_t                  mode_reg, mode_reg_next;
  stage_t                 pulse_stage, pulse_stage_next;
  event_t                 pending_event, pending_event_next;
  logic [TIME_WIDTH-1:0]  pending_on, pending_on_next;
  logic [TIME_WIDTH-1:0]  pending_off, pending_off_next;
  logic [TIME_WIDTH-1:0]  pending_total, pending_total_next;
  logic [TIME_WIDTH-1:0]  active_on, active_on_next;
  logic [TIME_WIDTH-1:0]  active_off, active_off_next;
  logic [TIME_WIDTH-1:0]  active_total, active_total_next;
  logic [TIMER_W-1:0]     mode_elapsed, mode_elapsed_next;
  logic [TIMER_W-1:0]     phase_elapsed, phase_elapsed_next;
  logic [TIME_WIDTH-1:0]  final_remaining, final_remaining_next;
  logic                   level_reg, level_reg_next;
  err_t                   err;

  logic [TIME_WIDTH-1:0]  cmd_on, cmd_per, cmd_tot, cmd_off;
  logic [TIME_WIDTH-1:0]  phase_len;
  logic [TIMER_W:0]       phase_end;

  assign cmd_on  = TIME_WIDTH'(item.on_time[IW-1:0]);
  assign cmd_per = TIME_WIDTH'(item.period[IW-1:0]);
  assign cmd_tot = TIME_WIDTH'(item.total_time[IW-1:0]);
  assign cmd_off = cmd_per - cmd_on;

  always_comb begin
    mode_reg_next        = mode_reg;
    pulse_stage_next     = pulse_stage;
    pending_event_next   = pending_event;
    pending_on_next      = pending_on;
    pending_off_next     = pending_off;
    pending_total_next   = pending_total;
    active_on_next       = active_on;
    active_off_next      = active_off;
    active_total_next    = active_total;
    mode_elapsed_next    = mode_elapsed;
    phase_elapsed_next   = phase_elapsed;
    final_remaining_next = final_remaining;
    level_reg_next       = level_reg;
    err                  = ERR_OK;
    phase_len            = '0;
    phase_end            = '0;

    case (item.kind)
      KIND_TICK: begin
        mode_elapsed_next  = mode_elapsed + 1'b1;
        phase_elapsed_next = phase_elapsed + 1'b1;

        // A pending event takes effect at the start of the tick.
        case (pending_event)
          EV_ON: begin
            mode_reg_next  = MODE_ON;
            level_reg_next = 1'b1;
          end
          EV_OFF: begin
            mode_reg_next  = MODE_OFF;
            level_reg_next = 1'b0;
          end
          EV_PULSE: begin
            mode_reg_next     = MODE_PULSE;
            active_on_next    = pending_on;
            active_off_next   = pending_off;
            active_total_next = pending_total;
            pulse_stage_next  = ST_TO_ON;
          end
          default: begin
          end
        endcase
        if (pending_event != EV_NONE) begin
          mode_elapsed_next  = '0;
          pending_event_next = EV_NONE;
        end

        if (mode_reg_next == MODE_PULSE) begin
          phase_len = (pulse_stage_next == ST_TO_ON) ? active_on_next : active_off_next;
          phase_end = {1'b0, mode_elapsed_next} + (TIMER_W + 1)'(phase_len);
          case (pulse_stage_next)
            ST_TO_ON, ST_TO_OFF: begin
              level_reg_next     = (pulse_stage_next == ST_TO_ON);
              phase_elapsed_next = '0;
              if (phase_end >= (TIMER_W + 1)'(active_total_next)) begin
                pulse_stage_next = ST_FINAL;
                if (mode_elapsed_next >= TIMER_W'(active_total_next)) begin
                  final_remaining_next = '0;
                end else begin
                  final_remaining_next = active_total_next
                                         - mode_elapsed_next[TIME_WIDTH-1:0];
                end
              end else begin
                pulse_stage_next = (pulse_stage_next == ST_TO_ON) ? ST_WAIT_OFF
                                                                  : ST_WAIT_ON;
              end
            end
            ST_WAIT_OFF: begin
              if (phase_elapsed_next >= TIMER_W'(active_on_next)) begin
                pulse_stage_next = ST_TO_OFF;
              end
            end
            ST_WAIT_ON: begin
              if (phase_elapsed_next >= TIMER_W'(active_off_next)) begin
                pulse_stage_next = ST_TO_ON;
              end
            end
            ST_FINAL: begin
              if (phase_elapsed_next >= TIMER_W'(final_remaining)) begin
                pending_event_next = EV_OFF;
              end
            end
            default: begin
            end
          endcase
        end
      end
      KIND_ENABLE: begin
        pending_event_next = EV_ON;
      end
      KIND_DISABLE: begin
        pending_event_next = EV_OFF;
      end
      KIND_PULSE: begin
        // The first failing check names the error; a rejected command
        // leaves all state alone.
        if (cmd_on == '0) begin
          err = ERR_ZERO_ON;
        end else if (cmd_off == '0) begin
          err = ERR_ZERO_OFF;
        end else if (cmd_tot == '0) begin
          err = ERR_ZERO_TOTAL;
        end else begin
          pending_on_next    = cmd_on;
          pending_off_next   = cmd_off;
          pending_total_next = cmd_tot;
          pending_event_next = EV_PULSE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_OFF;
      pulse_stage     <= ST_TO_ON;
      pending_event   <= EV_NONE;
      pending_on      <= '0;
      pending_off     <= '0;
      pending_total   <= '0;
      active_on       <= '0;
      active_off      <= '0;
      active_total    <= '0;
      mode_elapsed    <= '0;
      phase_elapsed   <= '0;
      final_remaining <= '0;
      level_reg       <= 1'b0;
    end else if (step) begin
      mode_reg        <= mode_reg_next;
      pulse_stage     <= pulse_stage_next;
      pending_event   <= pending_event_next;
      pending_on      <= pending_on_next;
      pending_off     <= pending_off_next;
      pending_total   <= pending_total_next;
      active_on       <= active_on_next;
      active_off      <= active_off_next;
      active_total    <= active_total_next;
      mode_elapsed    <= mode_elapsed_next;
      phase_elapsed   <= phase_elapsed_next;
      final_remaining <= final_remaining_next;
      level_reg       <= level_reg_next;
    end
  end

  assign result.buzzer_level = level_reg_next;
  assign result.mode         = mode_reg_next;
  assign result.error        = err;

  // Off mode never sounds and on mode always does.
  `BPC_ASSERT_SAME(a_off_silent, mode_reg == MODE_OFF, level_reg == 1'b0)
  `BPC_ASSERT_SAME(a_on_sounds, mode_reg == MODE_ON, level_reg == 1'b1)
  // Commands are only latched; mode and level move on ticks alone.
  `BPC_ASSERT_NEXT(a_cmd_latched_only, step && (item.kind != KIND_TICK),
                   $stable(mode_reg) && $stable(level_reg))

endmodule

// ===== rtl/buzzer_pulse_controller_unit.sv =====
// Results are offered from a result register fed by the input register.
// Throughput: one transaction per cycle through an input register and a result register;
// while a result waits, the input register takes one more transaction and then stalls.
// Reset: synchronous active-high rst clears the pipeline valids and all mode,
// pending-command and timer state (mode off, buzzer silent).
// ----------------------------------------------------------------------------
// Buzzer pulse controller unit
// Off, on and pulse-train buzzer control driven by tick and command transactions.
// ----------------------------------------------------------------------------
module buzzer_pulse_controller_unit #(
  parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  bpc_item_if.sink     in_chan,
  bpc_result_if.source out_chan
);
  import bpc_pkg::*;

  // Input stage: holds one accepted transaction until the core consumes it.
  item_t   item_q;
  logic    item_valid;

  // Result stage: holds one finished result until the sink takes it.
  result_t result_q;
  result_t core_result;
  logic    result_valid;

  logic    result_free;
  logic    advance;

  // The result register can take a new value when it is empty or is being
  // drained this cycle. The input register refills whenever it empties.
  assign result_free   = !result_valid || out_chan.ready;
  assign advance       = item_valid && result_free;
  assign in_chan.ready = !item_valid || result_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        item_valid <= in_chan.valid;
      end
      if (result_free) begin
        result_valid <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_q.kind       <= kind_t'(in_chan.kind);
      item_q.on_time    <= in_chan.on_time;
      item_q.period     <= in_chan.period;
      item_q.total_time <= in_chan.total_time;
    end
    if (advance) begin
      result_q <= core_result;
    end
  end

  // The core updates its state exactly once per transaction, in order, when
  // the transaction moves from the input register into the result register.
  bpc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .result (core_result)
  );

  assign out_chan.valid        = result_valid;
  assign out_chan.buzzer_level = result_q.buzzer_level;
  assign out_chan.mode         = result_q.mode;
  assign out_chan.error        = result_q.error;

endmodule

// ===== verif/bpc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buzzer pulse controller result checker
// Watches the command and result channels, predicts the buzzer status that
// each accepted command transaction causes, and compares it field by field.
// ----------------------------------------------------------------------------
module bpc_checker (
  input  logic  clk,
  input  logic  rst,
  bpc_item_if   in_chan,
  bpc_result_if out_chan,
  output int    fail_count,
  output int    outstanding,
  output int    results_seen,
  output int    pulse_results,
  output int    rejected_cmds
);
  import bpc_pkg::*;

  // Predicted controller state.
  mode_t              cur_mode;
  stage_t             cur_stage;
  event_t             queued_event;
  logic [FIELD_W-1:0] next_on, next_off, next_total;
  logic [FIELD_W-1:0] run_on, run_off, run_total;
  logic [TIMER_W-1:0] mode_ms, phase_ms;
  logic [16:0]        final_ms;
  logic               level;

  result_t status_queue[$];

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    results_seen  = 0;
    pulse_results = 0;
    rejected_cmds = 0;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  // Starts an on or off phase; when it would reach the total time, the
  // remainder becomes a final delay instead.
  task automatic begin_phase(input logic lvl, input logic [FIELD_W-1:0] len,
                             input stage_t wait_stage);
    logic [TIMER_W:0] reach;
    reach = {1'b0, mode_ms} + (TIMER_W+1)'(len);
    level    = lvl;
    phase_ms = '0;
    if (reach >= (TIMER_W+1)'(run_total)) begin
      cur_stage = ST_FINAL;
      final_ms  = (mode_ms >= TIMER_W'(run_total)) ? 17'd0
                                                   : 17'(TIMER_W'(run_total) - mode_ms);
    end else begin
      cur_stage = wait_stage;
    end
  endtask

  task automatic advance_buzzer(input item_t it, output result_t res);
    logic [FIELD_W-1:0] off_len;
    err_t               code;
    code = ERR_OK;
    case (it.kind)
      KIND_TICK: begin
        mode_ms  += 1;
        phase_ms += 1;
        // A pending command takes effect at the start of the tick.
        if (queued_event != EV_NONE) begin
          case (queued_event)
            EV_ON: begin
              cur_mode = MODE_ON;
              level    = 1'b1;
            end
            EV_OFF: begin
              cur_mode = MODE_OFF;
              level    = 1'b0;
            end
            default: begin
              cur_mode  = MODE_PULSE;
              run_on    = next_on;
              run_off   = next_off;
              run_total = next_total;
              cur_stage = ST_TO_ON;
            end
          endcase
          mode_ms      = '0;
          queued_event = EV_NONE;
        end
        if (cur_mode == MODE_PULSE) begin
          case (cur_stage)
            ST_TO_ON:    begin_phase(1'b1, run_on, ST_WAIT_OFF);
            ST_WAIT_OFF: if (phase_ms >= TIMER_W'(run_on)) cur_stage = ST_TO_OFF;
            ST_TO_OFF:   begin_phase(1'b0, run_off, ST_WAIT_ON);
            ST_WAIT_ON:  if (phase_ms >= TIMER_W'(run_off)) cur_stage = ST_TO_ON;
            ST_FINAL:    if (phase_ms >= TIMER_W'(final_ms)) queued_event = EV_OFF;
            default: ;
          endcase
        end
      end
      KIND_ENABLE:  queued_event = EV_ON;
      KIND_DISABLE: queued_event = EV_OFF;
      default: begin
        off_len = it.period - it.on_time;
        if (it.on_time == '0) begin
          code = ERR_ZERO_ON;
        end else if (off_len == '0) begin
          code = ERR_ZERO_OFF;
        end else if (it.total_time == '0) begin
          code = ERR_ZERO_TOTAL;
        end else begin
          next_on      = it.on_time;
          next_off     = off_len;
          next_total   = it.total_time;
          queued_event = EV_PULSE;
        end
      end
    endcase
    res.buzzer_level = level;
    res.mode         = cur_mode;
    res.error        = code;
  endtask

  always @(posedge clk) begin
    item_t   cmd;
    result_t want;
    if (rst) begin
      cur_mode     = MODE_OFF;
      cur_stage    = ST_TO_ON;
      queued_event = EV_NONE;
      next_on      = '0;
      next_off     = '0;
      next_total   = '0;
      run_on       = '0;
      run_off      = '0;
      run_total    = '0;
      mode_ms      = '0;
      phase_ms     = '0;
      final_ms     = '0;
      level        = 1'b0;
      status_queue.delete();
    end else begin
      // Results are checked before the new command is predicted, since a
      // command never shows up at the output in the cycle it is accepted.
      if (out_chan.valid && out_chan.ready) begin
        if (status_queue.size() == 0) begin
          flag_error("result transaction with no command waiting for it");
        end else begin
          want = status_queue.pop_front();
          results_seen++;
          if (out_chan.buzzer_level !== want.buzzer_level)
            flag_error($sformatf("result %0d buzzer_level: expected %0d, got %0d",
                                 results_seen, want.buzzer_level, out_chan.buzzer_level));
          if (out_chan.mode !== want.mode)
            flag_error($sformatf("result %0d mode: expected %0d, got %0d",
                                 results_seen, want.mode, out_chan.mode));
          if (out_chan.error !== want.error)
            flag_error($sformatf("result %0d error: expected %0d, got %0d",
                                 results_seen, want.error, out_chan.error));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        cmd.kind       = kind_t'(in_chan.kind);
        cmd.on_time    = in_chan.on_time;
        cmd.period     = in_chan.period;
        cmd.total_time = in_chan.total_time;
        advance_buzzer(cmd, want);
        if (want.mode == MODE_PULSE) pulse_results++;
        if (want.error != ERR_OK) rejected_cmds++;
        status_queue.push_back(want);
      end
    end
    outstanding = status_queue.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buzzer pulse controller testbench
// Drives tick and command transactions into the controller with random gaps
// on both channels, including one long receiver stall, and leaves all
// prediction and comparison to the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb;
  import bpc_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int LONG_HOLD    = 200;   // cycles of the long receiver stall
  localparam int HOLD_AT      = 400;   // result count at which the stall starts

  logic clk;
  logic rst;

  int fail_count, outstanding, results_seen, pulse_results, rejected_cmds;
  int sent_count;

  bpc_item_if   cmd_chan ();
  bpc_result_if status_chan ();

  buzzer_pulse_controller_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (cmd_chan),
    .out_chan (status_chan)
  );

  // The checker watches both channels and only reports counts back here.
  bpc_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_chan       (cmd_chan),
    .out_chan      (status_chan),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .pulse_results (pulse_results),
    .rejected_cmds (rejected_cmds)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout: results still outstanding");
    $display("FAILED: results differ");
    $finish;
  end

  // A command transaction whose unused fields carry random junk, so that the
  // block is seen to ignore them.
  function automatic item_t plain_item(input kind_t k);
    item_t it;
    it.kind       = k;
    it.on_time    = FIELD_W'($urandom);
    it.period     = FIELD_W'($urandom);
    it.total_time = FIELD_W'($urandom);
    return it;
  endfunction

  function automatic item_t pulse_item(input int on_ms, input int per_ms, input int tot_ms);
    item_t it;
    it.kind       = KIND_PULSE;
    it.on_time    = FIELD_W'(on_ms);
    it.period     = FIELD_W'(per_ms);
    it.total_time = FIELD_W'(tot_ms);
    return it;
  endfunction

  // The sender alternates between stretches with random gaps and stretches
  // with none, so that gaps land on every phase of the pulse sequence.
  bit send_gappy = 1'b1;

  task automatic send_item(input item_t it);
    int gap;
    if ($urandom_range(0, 49) == 0) send_gappy = !send_gappy;
    gap = send_gappy ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_chan.valid      <= 1'b1;
    cmd_chan.kind       <= it.kind;
    cmd_chan.on_time    <= it.on_time;
    cmd_chan.period     <= it.period;
    cmd_chan.total_time <= it.total_time;
    // Valid stays high after acceptance; the next call decides whether it drops.
    do @(posedge clk); while (!cmd_chan.ready);
    sent_count++;
  endtask

  // Receiver: random hold-offs per transaction, quiet stretches, and one long
  // stall that lets the pipeline fill up and push back on the sender.
  initial begin
    int  gap;
    int  taken;
    bit  recv_gappy;
    status_chan.ready <= 1'b0;
    taken      = 0;
    recv_gappy = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_gappy = !recv_gappy;
      gap = recv_gappy ? $urandom_range(0, 5) : 0;
      if (taken == HOLD_AT) gap = LONG_HOLD;
      if (gap > 0) begin
        status_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      status_chan.ready <= 1'b1;
      do @(posedge clk); while (!status_chan.valid);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int    on_ms, off_ms, tot_ms, ticks, n;
    item_t it;
    rst                 = 1'b1;
    cmd_chan.valid      <= 1'b0;
    cmd_chan.kind       <= KIND_TICK;
    cmd_chan.on_time    <= '0;
    cmd_chan.period     <= '0;
    cmd_chan.total_time <= '0;
    sent_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: each mode, re-entry, every rejection code, off-time
    // wrap, command overwrite and a short pulse train run to its end.
    send_item(plain_item(KIND_TICK));
    send_item(plain_item(KIND_ENABLE));
    send_item(plain_item(KIND_TICK));
    send_item(plain_item(KIND_ENABLE));              // re-enter on mode
    send_item(plain_item(KIND_TICK));
    send_item(pulse_item(0, 16'h1234, 10));          // zero on time
    send_item(pulse_item(5, 5, 10));                 // zero off time
    send_item(pulse_item(16'hFFFF, 16'hFFFE, 16'hFFFF)); // off wraps to all ones
    send_item(plain_item(KIND_DISABLE));             // overwrites the pending pulse
    send_item(plain_item(KIND_TICK));
    send_item(pulse_item(3, 1, 0));                  // wrapped off time, zero total
    send_item(pulse_item(1, 3, 4));
    repeat (3) send_item(plain_item(KIND_TICK));
    send_item(pulse_item(1, 3, 4));                  // restart pulse mid-run
    repeat (8) send_item(plain_item(KIND_TICK));     // runs out and returns to off

    // Random part: mostly well-formed pulse trains with random timing and a
    // run of ticks at least as long as their total time, mixed with noise episodes.
    n = sent_count;
    while (sent_count < n + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        on_ms  = $urandom_range(1, 6);
        off_ms = $urandom_range(1, 6);
        tot_ms = $urandom_range(1, 40);
        if ($urandom_range(0, 7) == 0) begin
          it = pulse_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
        end else if ($urandom_range(0, 9) == 0) begin
          // Occasionally a malformed command with a zero on, off or total time.
          case ($urandom_range(0, 2))
            0:       it = pulse_item(0, on_ms + off_ms, tot_ms);
            1:       it = pulse_item(on_ms, on_ms, tot_ms);
            default: it = pulse_item(on_ms, on_ms + off_ms, 0);
          endcase
        end else begin
          it = pulse_item(on_ms, on_ms + off_ms, tot_ms);
        end
        send_item(it);
        ticks = tot_ms + $urandom_range(0, 10);
        if (ticks > 60) ticks = 60;
        repeat (ticks) begin
          if ($urandom_range(0, 19) == 0)
            send_item(plain_item(kind_t'($urandom_range(1, 3))));
          else
            send_item(plain_item(KIND_TICK));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1) == 0)
            send_item(plain_item(KIND_TICK));
          else
            send_item(plain_item(kind_t'($urandom_range(0, 3))));
        end
      end
    end

    @(negedge clk);
    cmd_chan.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d command transactions and %0d checked results, %0d in pulse mode.",
             sent_count, results_seen, pulse_results);
    $display("It included %0d rejected pulse commands and one long receiver stall.",
             rejected_cmds);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
